// ----- hdl/twl_pkg.sv -----
// Shared types, constants and helper functions of the twist acceleration window limiter.
package twl_pkg;

  // Velocity format: signed fixed point, FRAC_BITS of VEL_BITS bits fractional.
  localparam int VEL_BITS  = 24;
  localparam int FRAC_BITS = 16;
  localparam int STEP_BITS = VEL_BITS - 1;
  localparam int NAX       = 3;
  // Delta width, numerator / remainder width, quotient width, factor width.
  localparam int DW = VEL_BITS + 1;
  localparam int NW = VEL_BITS + 2;
  localparam int QW = FRAC_BITS + 1;
  localparam int FW = FRAC_BITS + 3;
  // Width of the final sum before saturation.
  localparam int SW = VEL_BITS + 4;

  localparam logic signed [FW-1:0] F_ONE  = FW'(1) << FRAC_BITS;
  localparam logic signed [FW-1:0] F_NEG2 = -(F_ONE + F_ONE);

  localparam logic signed [SW-1:0] VEL_MAX = SW'((64'd1 << (VEL_BITS - 1)) - 64'd1);
  localparam logic signed [SW-1:0] VEL_MIN = -VEL_MAX - SW'(1);

  typedef logic signed [VEL_BITS-1:0] vel_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_STEP_X    = 2'd0,
    REG_STEP_Y    = 2'd1,
    REG_STEP_TURN = 2'd2,
    REG_PROP_MODE = 2'd3
  } cfg_reg_t;

  // How one axis enters the factor minimum.
  typedef enum logic [1:0] {
    DIV_NORMAL = 2'd0,
    DIV_SAT_HI = 2'd1,
    DIV_SAT_LO = 2'd2,
    DIV_SKIP   = 2'd3
  } div_class_t;

  typedef struct packed {
    logic [NAX-1:0][STEP_BITS-1:0] step;
    logic                          prop;
  } cfg_t;

  typedef struct packed {
    vel_t now_x;
    vel_t now_y;
    vel_t now_turn;
    vel_t want_x;
    vel_t want_y;
    vel_t want_turn;
    vel_t floor_x;
    vel_t floor_y;
    vel_t floor_turn;
    vel_t ceil_x;
    vel_t ceil_y;
    vel_t ceil_turn;
  } in_item_t;

  typedef struct packed {
    vel_t out_x;
    vel_t out_y;
    vel_t out_turn;
    logic was_changed;
  } out_item_t;

  // One axis after classification.
  typedef struct packed {
    vel_t                 now;
    vel_t                 want;
    logic signed [DW-1:0] delta;
    vel_t                 clip;
    div_class_t           cls;
    logic                 neg;
    logic [NW-1:0]        num_mag;
    logic [DW-1:0]        den;
  } lane_job_t;

  typedef struct packed {
    logic                     prop;
    lane_job_t [NAX-1:0]      lane;
  } job_t;

  // Factor of one axis from its class, sign and quotient.
  function automatic logic signed [FW-1:0] factor_of(div_class_t cls, logic neg,
                                                     logic [QW-1:0] quo);
    logic signed [FW-1:0] mag;
    logic signed [FW-1:0] f;
    mag = $signed(FW'(quo));
    unique case (cls)
      DIV_NORMAL: f = neg ? -mag : mag;
      DIV_SAT_LO: f = F_NEG2;
      DIV_SAT_HI: f = F_ONE;
      DIV_SKIP:   f = F_ONE;
      default:    f = F_ONE;
    endcase
    return f;
  endfunction

  // Saturate a wide sum to the velocity range.
  function automatic vel_t sat_vel(logic signed [SW-1:0] v);
    logic signed [SW-1:0] s;
    s = v;
    if (v > VEL_MAX) s = VEL_MAX;
    if (v < VEL_MIN) s = VEL_MIN;
    return s[VEL_BITS-1:0];
  endfunction

endpackage

// ----- hdl/twist_accel_window_limiter.sv -----
// Top level of the twist acceleration window limiter: registers, front, queue and back.
// Takes one item per clock cycle with no stall of its own. Velocities are in the Q8.16
// format. The factor divider forms one quotient bit per pipeline stage, followed by the
// minimum, multiply and output stages. Full and empty follow a queue: the input side
// stalls only when the result is not popped. Configuration writes take effect for items
// accepted afterwards and are meant to be done while the block is idle.
module twist_accel_window_limiter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  twl_pkg::in_item_t             in_item,
  output logic                          in_full,
  output logic                          out_empty,
  input  logic                          out_pop,
  output twl_pkg::out_item_t            out_item,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_idx,
  input  logic [twl_pkg::STEP_BITS-1:0] cfg_data
);

  twl_pkg::cfg_t cfg_r;
  twl_pkg::cfg_reg_t cfg_sel;
  logic          q_push, q_full, q_pop, q_empty;
  twl_pkg::job_t q_in_job, q_out_job;

  assign cfg_sel = twl_pkg::cfg_reg_t'(cfg_idx);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        twl_pkg::REG_STEP_X:    cfg_r.step[0] <= cfg_data;
        twl_pkg::REG_STEP_Y:    cfg_r.step[1] <= cfg_data;
        twl_pkg::REG_STEP_TURN: cfg_r.step[2] <= cfg_data;
        twl_pkg::REG_PROP_MODE: cfg_r.prop    <= cfg_data[0];
        default:                cfg_r         <= cfg_r;
      endcase
    end
  end

  twl_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .cfg     (cfg_r),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (q_in_job)
  );

  twl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_in_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (q_out_job),
    .empty    (q_empty)
  );

  twl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (q_out_job),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

  // The pipeline comes out of reset with nothing in flight.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> out_empty && q_empty)
    else $error("pipeline not empty after reset");

  // The input side stalls only while the queue is full.
  a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> q_full)
    else $error("input stalled while the queue has room");

  // The back part never takes from an empty queue.
  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("back part read an empty queue");

endmodule

// ----- hdl/twl_front.sv -----
// Front part: accepts items, forms the axis windows and classifies each axis.
module twl_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  twl_pkg::in_item_t in_item,
  output logic              in_full,
  input  twl_pkg::cfg_t     cfg,
  input  logic              q_full,
  output logic              q_push,
  output twl_pkg::job_t     q_job
);

  localparam int NW = twl_pkg::NW;
  localparam int DW = twl_pkg::DW;

  logic          f_v_r;
  twl_pkg::job_t f_job_r;
  twl_pkg::job_t job_nxt;
  logic          adv;

  twl_pkg::vel_t now_a   [twl_pkg::NAX];
  twl_pkg::vel_t want_a  [twl_pkg::NAX];
  twl_pkg::vel_t floor_a [twl_pkg::NAX];
  twl_pkg::vel_t ceil_a  [twl_pkg::NAX];

  assign now_a   = '{in_item.now_x,   in_item.now_y,   in_item.now_turn};
  assign want_a  = '{in_item.want_x,  in_item.want_y,  in_item.want_turn};
  assign floor_a = '{in_item.floor_x, in_item.floor_y, in_item.floor_turn};
  assign ceil_a  = '{in_item.ceil_x,  in_item.ceil_y,  in_item.ceil_turn};

  // Window, clip result and division operands of each axis.
  always_comb begin
    logic signed [NW-1:0] nw, ww, fl, cl, st, lo, hi, t, clip, num;
    logic signed [DW-1:0] dl;
    logic [DW-1:0]        den;
    logic signed [NW:0]   numx, denx;
    job_nxt = '0;
    job_nxt.prop = cfg.prop;
    for (int k = 0; k < twl_pkg::NAX; k++) begin
      nw = NW'(now_a[k]);
      ww = NW'(want_a[k]);
      fl = NW'(floor_a[k]);
      cl = NW'(ceil_a[k]);
      st = $signed(NW'(cfg.step[k]));
      lo = (fl > nw - st) ? fl : nw - st;
      hi = (cl < nw + st) ? cl : nw + st;
      t    = (ww > lo) ? ww : lo;
      clip = (t < hi) ? t : hi;
      dl = DW'(want_a[k]) - DW'(now_a[k]);
      if (dl > 0) begin
        num = hi - nw;
        den = dl;
      end else begin
        num = nw - lo;
        den = -dl;
      end
      numx = (NW+1)'(num);
      denx = $signed({2'b00, den});
      job_nxt.lane[k].now     = now_a[k];
      job_nxt.lane[k].want    = want_a[k];
      job_nxt.lane[k].delta   = dl;
      job_nxt.lane[k].clip    = clip[twl_pkg::VEL_BITS-1:0];
      job_nxt.lane[k].neg     = num < 0;
      job_nxt.lane[k].num_mag = (num < 0) ? -num : num;
      job_nxt.lane[k].den     = den;
      if (dl == 0) begin
        job_nxt.lane[k].cls = twl_pkg::DIV_SKIP;
      end else if (numx >= denx) begin
        job_nxt.lane[k].cls = twl_pkg::DIV_SAT_HI;
      end else if (numx <= -(denx + denx)) begin
        job_nxt.lane[k].cls = twl_pkg::DIV_SAT_LO;
      end else begin
        job_nxt.lane[k].cls = twl_pkg::DIV_NORMAL;
      end
    end
  end

  // The front register moves on whenever the queue can take its item.
  assign adv     = !f_v_r || !q_full;
  assign in_full = !adv;
  assign q_push  = f_v_r && !q_full;
  assign q_job   = f_job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (adv) begin
      f_v_r <= in_push;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_job_r <= job_nxt;
    end
  end

endmodule

// ----- hdl/twl_queue.sv -----
// Two-entry queue of classified items between the front and back parts.
module twl_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  twl_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output twl_pkg::job_t pop_job,
  output logic          empty
);

  twl_pkg::job_t mem_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign pop_job = mem_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ----- hdl/twl_back.sv -----
// Back part: bit-per-stage factor division, minimum, scaling and output register.
module twl_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  twl_pkg::job_t      q_job,
  output logic               q_pop,
  input  logic               out_pop,
  output logic               out_empty,
  output twl_pkg::out_item_t out_item
);

  localparam int NAX = twl_pkg::NAX;
  localparam int NW  = twl_pkg::NW;
  localparam int QW  = twl_pkg::QW;
  localparam int FW  = twl_pkg::FW;
  localparam int DW  = twl_pkg::DW;
  localparam int SW  = twl_pkg::SW;
  localparam int FB  = twl_pkg::FRAC_BITS;
  localparam int PW  = DW + FB + 2;

  logic en;
  logic out_v_r;

  // Every back stage advances together when the output register is free.
  assign en        = !out_v_r || out_pop;
  assign q_pop     = en && !q_empty;
  assign out_empty = !out_v_r;

  logic          dv_r   [QW];
  twl_pkg::job_t djob_r [QW];
  logic [NW-1:0] rem_r  [QW][NAX];
  logic [QW-1:0] quo_r  [QW][NAX];

  // Division stages: one quotient bit per stage for each axis.
  for (genvar s = 0; s < QW; s++) begin : g_div
    logic          sv;
    twl_pkg::job_t sj;
    logic [NW-1:0] srem [NAX];
    logic [QW-1:0] squo [NAX];
    logic [NW-1:0] nrem [NAX];
    logic [QW-1:0] nquo [NAX];

    if (s == 0) begin : g_first
      assign sv = !q_empty;
      assign sj = q_job;
      for (genvar k = 0; k < NAX; k++) begin : g_ld
        assign srem[k] = q_job.lane[k].num_mag;
        assign squo[k] = '0;
      end
    end else begin : g_next
      assign sv = dv_r[s-1];
      assign sj = djob_r[s-1];
      for (genvar k = 0; k < NAX; k++) begin : g_ld
        assign srem[k] = rem_r[s-1][k];
        assign squo[k] = quo_r[s-1][k];
      end
    end

    for (genvar k = 0; k < NAX; k++) begin : g_lane
      always_comb begin
        logic [NW-1:0] rs;
        logic [NW-1:0] d;
        rs = (s == 0) ? srem[k] : {srem[k][NW-2:0], 1'b0};
        d  = NW'(sj.lane[k].den);
        if (rs >= d) begin
          nrem[k] = rs - d;
          nquo[k] = {squo[k][QW-2:0], 1'b1};
        end else begin
          nrem[k] = rs;
          nquo[k] = {squo[k][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[s] <= 1'b0;
      end else if (en) begin
        dv_r[s] <= sv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        djob_r[s] <= sj;
        for (int k = 0; k < NAX; k++) begin
          rem_r[s][k] <= nrem[k];
          quo_r[s][k] <= nquo[k];
        end
      end
    end
  end

  // Minimum stage: smallest axis factor.
  logic                 mv_r;
  twl_pkg::job_t        mjob_r;
  logic signed [FW-1:0] fmin_r;
  logic signed [FW-1:0] fmin_nxt;

  always_comb begin
    logic signed [FW-1:0] f [NAX];
    for (int k = 0; k < NAX; k++) begin
      f[k] = twl_pkg::factor_of(djob_r[QW-1].lane[k].cls, djob_r[QW-1].lane[k].neg,
                                quo_r[QW-1][k]);
    end
    fmin_nxt = (f[0] < f[1]) ? f[0] : f[1];
    fmin_nxt = (f[2] < fmin_nxt) ? f[2] : fmin_nxt;
  end

  // Multiply stage: delta magnitude times factor magnitude.
  logic          pv_r;
  twl_pkg::job_t pjob_r;
  logic          pass_r;
  logic [PW-1:0] prod_r [NAX];
  logic          pneg_r [NAX];
  logic [PW-1:0] prod_nxt [NAX];
  logic          pneg_nxt [NAX];

  always_comb begin
    logic [DW-1:0]        dmag;
    logic signed [FW-1:0] fneg;
    logic [FB+1:0]        fmag;
    fneg = -fmin_r;
    fmag = (fmin_r < 0) ? fneg[FB+1:0] : fmin_r[FB+1:0];
    for (int k = 0; k < NAX; k++) begin
      dmag = (mjob_r.lane[k].delta < 0) ? -mjob_r.lane[k].delta : mjob_r.lane[k].delta;
      prod_nxt[k] = PW'(dmag) * PW'(fmag);
      pneg_nxt[k] = (mjob_r.lane[k].delta < 0) != (fmin_r < 0);
    end
  end

  // Output stage: clip result, or in proportional mode add to the current velocity and saturate; compare with command.
  twl_pkg::out_item_t out_r;
  twl_pkg::out_item_t out_nxt;

  always_comb begin
    logic [PW-FB-1:0]     m;
    logic signed [SW-1:0] mterm;
    logic signed [SW-1:0] sum;
    twl_pkg::vel_t        res [NAX];
    logic                 chg;
    chg = 1'b0;
    for (int k = 0; k < NAX; k++) begin
      m     = prod_r[k][PW-1:FB];
      mterm = $signed(SW'(m));
      sum   = SW'(pjob_r.lane[k].now) + (pneg_r[k] ? -mterm : mterm);
      if (!pjob_r.prop) begin
        res[k] = pjob_r.lane[k].clip;
      end else if (pass_r) begin
        res[k] = pjob_r.lane[k].want;
      end else begin
        res[k] = twl_pkg::sat_vel(sum);
      end
      if (res[k] != pjob_r.lane[k].want) chg = 1'b1;
    end
    out_nxt.out_x       = res[0];
    out_nxt.out_y       = res[1];
    out_nxt.out_turn    = res[2];
    out_nxt.was_changed = chg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r    <= 1'b0;
      pv_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      mv_r    <= dv_r[QW-1];
      pv_r    <= mv_r;
      out_v_r <= pv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mjob_r <= djob_r[QW-1];
      fmin_r <= fmin_nxt;
      pjob_r <= mjob_r;
      pass_r <= fmin_r >= twl_pkg::F_ONE;
      for (int k = 0; k < NAX; k++) begin
        prod_r[k] <= prod_nxt[k];
        pneg_r[k] <= pneg_nxt[k];
      end
      out_r <= out_nxt;
    end
  end

  assign out_item = out_r;

endmodule

// ----- verif/twl_checker.sv -----
// Checker of the twist acceleration window limiter: predicts each result and compares it.
`timescale 1ns / 1ps

module twl_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  twl_pkg::in_item_t             in_item,
  input  logic                          in_full,
  input  logic                          out_empty,
  input  logic                          out_pop,
  input  twl_pkg::out_item_t            out_item,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_idx,
  input  logic [twl_pkg::STEP_BITS-1:0] cfg_data,
  output int                            fail_count,
  output int                            pending_count
);

  localparam longint VMAXL = (64'sd1 <<< (twl_pkg::VEL_BITS - 1)) - 1;
  localparam longint VMINL = -VMAXL - 1;
  localparam longint FONEL = 64'sd1 <<< twl_pkg::FRAC_BITS;

  // Shadow copy of the configuration registers.
  longint shadow_step [3];
  logic   shadow_prop;

  twl_pkg::out_item_t expected_twists [$];

  // Feasibility factor num/den (den > 0), truncated toward zero, saturated to [-2, 1].
  function automatic longint axis_factor(longint num, longint den);
    longint q;
    if (num >= den) return FONEL;
    if (num <= -2 * den) return -2 * FONEL;
    q = ((num < 0 ? -num : num) <<< twl_pkg::FRAC_BITS) / den;
    return num < 0 ? -q : q;
  endfunction

  // Delta times factor, magnitude truncated toward zero.
  function automatic longint scaled_delta(longint d, longint f);
    longint m;
    m = ((d < 0 ? -d : d) * (f < 0 ? -f : f)) >>> twl_pkg::FRAC_BITS;
    return ((d < 0) != (f < 0)) ? -m : m;
  endfunction

  function automatic longint clamp_vel(longint v);
    if (v > VMAXL) return VMAXL;
    if (v < VMINL) return VMINL;
    return v;
  endfunction

  function automatic twl_pkg::out_item_t limit_twist(twl_pkg::in_item_t it);
    longint now [3], want [3], lo [3], hi [3], dl [3], res [3];
    longint fmin, f;
    twl_pkg::out_item_t o;
    now[0] = it.now_x; now[1] = it.now_y; now[2] = it.now_turn;
    want[0] = it.want_x; want[1] = it.want_y; want[2] = it.want_turn;
    lo[0] = it.floor_x; lo[1] = it.floor_y; lo[2] = it.floor_turn;
    hi[0] = it.ceil_x; hi[1] = it.ceil_y; hi[2] = it.ceil_turn;
    fmin = FONEL;
    for (int k = 0; k < 3; k++) begin
      if (now[k] - shadow_step[k] > lo[k]) lo[k] = now[k] - shadow_step[k];
      if (now[k] + shadow_step[k] < hi[k]) hi[k] = now[k] + shadow_step[k];
      dl[k] = want[k] - now[k];
    end
    for (int k = 0; k < 3; k++) begin
      if (!shadow_prop) begin
        res[k] = want[k] < lo[k] ? lo[k] : want[k];
        if (res[k] > hi[k]) res[k] = hi[k];
      end else if (dl[k] != 0) begin
        f = dl[k] > 0 ? axis_factor(hi[k] - now[k], dl[k])
                      : axis_factor(now[k] - lo[k], -dl[k]);
        if (f < fmin) fmin = f;
      end
    end
    if (shadow_prop) begin
      for (int k = 0; k < 3; k++)
        res[k] = fmin >= FONEL ? want[k] : now[k] + scaled_delta(dl[k], fmin);
    end
    o.was_changed = 1'b0;
    for (int k = 0; k < 3; k++) begin
      res[k] = clamp_vel(res[k]);
      if (res[k] != want[k]) o.was_changed = 1'b1;
    end
    o.out_x = twl_pkg::vel_t'(res[0]);
    o.out_y = twl_pkg::vel_t'(res[1]);
    o.out_turn = twl_pkg::vel_t'(res[2]);
    return o;
  endfunction

  assign pending_count = expected_twists.size();

  // Track configuration, predict accepted items and compare popped results.
  always @(posedge clk) begin
    twl_pkg::out_item_t want_o;
    if (!rst_n) begin
      shadow_step = '{0, 0, 0};
      shadow_prop = 1'b0;
      fail_count <= 0;
    end else begin
      if (in_push && !in_full) expected_twists.push_back(limit_twist(in_item));
      if (out_pop && !out_empty) begin
        if (expected_twists.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", out_item);
          fail_count <= fail_count + 1;
        end else begin
          want_o = expected_twists.pop_front();
          if (want_o.out_x !== out_item.out_x || want_o.out_y !== out_item.out_y ||
              want_o.out_turn !== out_item.out_turn ||
              want_o.was_changed !== out_item.was_changed) begin
            if (fail_count < 10)
              $display("mismatch: expected %h, got %h", want_o, out_item);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_we) begin
        case (twl_pkg::cfg_reg_t'(cfg_idx))
          twl_pkg::REG_PROP_MODE: shadow_prop = cfg_data[0];
          default:                shadow_step[cfg_idx] = longint'(cfg_data);
        endcase
      end
    end
  end
endmodule

// ----- verif/testbench.sv -----
// Testbench top: drives the window limiter with directed and random items and gives the verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int SB = twl_pkg::STEP_BITS;
  localparam int LATENCY = twl_pkg::FRAC_BITS + 5;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0, rst_n = 1'b0;
  logic in_push = 1'b0, out_pop = 1'b0, cfg_we = 1'b0;
  logic in_full, out_empty;
  twl_pkg::in_item_t in_item = '0;
  twl_pkg::out_item_t out_item;
  logic [1:0] cfg_idx = '0;
  logic [SB-1:0] cfg_data = '0;
  int fail_count, pending_count, cycles = 0;
  int send_idle = 0, recv_idle = 0;

  twist_accel_window_limiter dut (.*);
  twl_checker chk (.*);

  initial forever #6 clk = ~clk;

  // Cycle limit guards against a hung block.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver pops with a random stall rate.
  always @(posedge clk) out_pop <= ($urandom_range(99) >= recv_idle);

  // Random velocity, biased toward extremes and small values.
  function automatic twl_pkg::vel_t pick_vel();
    case ($urandom_range(7))
      0: return twl_pkg::vel_t'(23'h7fffff);
      1: return twl_pkg::vel_t'(24'h800000);
      2: return twl_pkg::vel_t'($signed($urandom_range(4000)) - 2000);
      3: return '0;
      default: return twl_pkg::vel_t'($urandom);
    endcase
  endfunction

  // Mostly independent pick_vel fields, the command sometimes equal to the current velocity; else fully random.
  function automatic twl_pkg::in_item_t random_twist();
    twl_pkg::in_item_t t;
    t = twl_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom});
    if ($urandom_range(3) != 0) begin
      t.now_x = pick_vel(); t.now_y = pick_vel(); t.now_turn = pick_vel();
      t.want_x = $urandom_range(5) == 0 ? t.now_x : pick_vel();
      t.want_y = $urandom_range(5) == 0 ? t.now_y : pick_vel();
      t.want_turn = $urandom_range(5) == 0 ? t.now_turn : pick_vel();
      t.floor_x = pick_vel(); t.floor_y = pick_vel(); t.floor_turn = pick_vel();
      t.ceil_x = pick_vel(); t.ceil_y = pick_vel(); t.ceil_turn = pick_vel();
    end
    return t;
  endfunction

  task automatic send_twist(twl_pkg::in_item_t t);
    while ($urandom_range(99) < send_idle) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= t;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // One register write; the caller drops the write enable after its last write.
  task automatic write_reg(twl_pkg::cfg_reg_t idx, logic [SB-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_limits(logic [SB-1:0] sx, logic [SB-1:0] sy,
                            logic [SB-1:0] st, logic prop);
    write_reg(twl_pkg::REG_STEP_X, sx);
    write_reg(twl_pkg::REG_STEP_Y, sy);
    write_reg(twl_pkg::REG_STEP_TURN, st);
    write_reg(twl_pkg::REG_PROP_MODE, {{(SB-1){1'b0}}, prop});
    cfg_we <= 1'b0;
  endtask

  initial begin
    twl_pkg::in_item_t t;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items in both modes: extremes, zero deltas, empty windows.
    for (int m = 0; m < 2; m++) begin
      set_limits(23'h7fffff, 23'd65536, 23'd0, m[0]);
      t = '0;
      send_twist(t);
      t.want_x = twl_pkg::vel_t'(23'h7fffff); t.ceil_x = twl_pkg::vel_t'(23'h7fffff);
      t.want_y = twl_pkg::vel_t'(24'h800000); t.floor_y = twl_pkg::vel_t'(24'h800000);
      t.ceil_y = twl_pkg::vel_t'(23'h7fffff); t.want_turn = 24'd5;
      send_twist(t);
      t.now_x = twl_pkg::vel_t'(23'h7fffff); t.now_y = twl_pkg::vel_t'(24'h800000);
      t.want_x = twl_pkg::vel_t'(24'h800000); t.want_y = twl_pkg::vel_t'(23'h7fffff);
      t.floor_x = twl_pkg::vel_t'(24'h800000); t.ceil_x = twl_pkg::vel_t'(23'h7fffff);
      send_twist(t);
      t.floor_x = 24'd1000; t.ceil_x = -24'sd1000;
      send_twist(t);
      t = '1;
      send_twist(t);
      drain();
      set_limits('0, '0, 23'h7fffff, m[0]);
      t = '0; t.want_turn = 24'd100; t.ceil_turn = 24'd50; t.floor_turn = -24'sd50;
      send_twist(t);
      drain();
    end

    // Random phases over several settings and idle profiles.
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 3)
        0: begin send_idle = 6; recv_idle = 56; end
        1: begin send_idle = 56; recv_idle = 6; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      if (ph == 11) set_limits(23'h7fffff, 23'h7fffff, 23'h7fffff, 1'b1);
      else set_limits(SB'($urandom_range(ph % 4 == 0 ? 23'h7fffff : 23'd200000)),
                      SB'($urandom), SB'($urandom_range(1000)), ph[0]);
      repeat (162) send_twist(random_twist());
      drain();
    end

    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

// ----- filelist.f -----
hdl/twl_pkg.sv
hdl/twl_front.sv
hdl/twl_queue.sv
hdl/twl_back.sv
hdl/twist_accel_window_limiter.sv
verif/twl_checker.sv
verif/testbench.sv
